@@ design/aat_pkg.sv @@
// Package for the box affine transform: widths, function codes, the stage
// enable bundle and the saturation helpers. No dependencies.
package aat_pkg;

  localparam int CW        = 32;            // coordinate width, signed Q16.16
  localparam int FB        = 16;            // fraction bits
  localparam int EW        = CW - 1;        // extent width, unsigned
  localparam int NUM_AXES  = 3;
  localparam int CPROD_W   = 2 * CW;        // exact signed center product
  localparam int CTERM_W   = CPROD_W - FB;  // product after the floor shift
  localparam int EPROD_W   = CW + EW;       // exact unsigned extent product
  localparam int ETERM_W   = EPROD_W - FB;
  localparam int CSUM_W    = CTERM_W + 2;   // three products plus translation
  localparam int ESUM_W    = ETERM_W + 2;   // three products

  localparam logic [1:0] ROW_INVALID = 2'd3;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_XFORM = 1'b1
  } func_e;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

  // Clamp a wide signed sum to the signed coordinate range.
  function automatic logic [CW-1:0] sat_center(input logic signed [CSUM_W-1:0] v);
    logic signed [CSUM_W-1:0] hi;
    logic signed [CSUM_W-1:0] lo;
    hi = {{(CSUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[CW-1:0];
    end else if (v < lo) begin
      return lo[CW-1:0];
    end else begin
      return v[CW-1:0];
    end
  endfunction

  // Clamp a non-negative wide sum to the extent range.
  function automatic logic [EW-1:0] sat_extent(input logic [ESUM_W-1:0] v);
    logic [ESUM_W-1:0] hi;
    hi = {{(ESUM_W-EW){1'b0}}, {EW{1'b1}}};
    if (v > hi) begin
      return hi[EW-1:0];
    end else begin
      return v[EW-1:0];
    end
  endfunction

endpackage

@@ design/aabb_affine_transform.sv @@
// Top level of the box affine transform: matrix registers, input capture
// stage, three row units and the valid/ready pipeline control.
// Depends on aat_pkg and aat_row.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries load and transform items.
//   A load item (func 0) writes coefficients and translation of one matrix
//   row at the accepting edge; row index three is dropped. Loads give no
//   result and take no pipeline slot. A transform item (func 1) produces one
//   result on the output channel (out_valid_o / out_ready_i): the new center
//   M*c + T in signed Q16.16 and the new extent |M|*e in unsigned Q15.16,
//   both saturated. Items pass through the capture, multiply, sum and
//   saturate stage registers in that order.
//   Throughput: one item per cycle unless the output stalls; eighteen
//   multipliers, two per matrix term (center and extent), work in parallel.
//   A transform reads the matrix as it stands when accepted, so a load right
//   before it takes effect and a load right after it does not.
//   Reset clears every stage valid bit and zeroes the matrix.
//   Stall: each stage advances when its successor is empty or advancing, so
//   bubbles close up and input is taken while a finished result waits at the
//   output; a full pipeline holds every item in place until out_ready_i.
module aabb_affine_transform import aat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [1:0]           row_index_i,
  input  logic signed [CW-1:0] coef_0_i,
  input  logic signed [CW-1:0] coef_1_i,
  input  logic signed [CW-1:0] coef_2_i,
  input  logic signed [CW-1:0] translation_i,
  input  logic signed [CW-1:0] center_x_i,
  input  logic signed [CW-1:0] center_y_i,
  input  logic signed [CW-1:0] center_z_i,
  input  logic [EW-1:0]        extent_x_i,
  input  logic [EW-1:0]        extent_y_i,
  input  logic [EW-1:0]        extent_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [CW-1:0] new_center_x_o,
  output logic signed [CW-1:0] new_center_y_o,
  output logic signed [CW-1:0] new_center_z_o,
  output logic [EW-1:0]        new_extent_x_o,
  output logic [EW-1:0]        new_extent_y_o,
  output logic [EW-1:0]        new_extent_z_o
);

  // Matrix state, cleared at reset.
  logic signed [CW-1:0] coef_q  [NUM_AXES][NUM_AXES];
  logic signed [CW-1:0] trans_q [NUM_AXES];

  // Stage 1 capture: matrix snapshot and box.
  logic signed [CW-1:0] coef_s1_q  [NUM_AXES][NUM_AXES];
  logic        [CW-1:0] abs_d      [NUM_AXES][NUM_AXES];
  logic        [CW-1:0] abs_s1_q   [NUM_AXES][NUM_AXES];
  logic signed [CW-1:0] trans_s1_q [NUM_AXES];
  logic signed [CW-1:0] center_d   [NUM_AXES];
  logic signed [CW-1:0] center_s1_q[NUM_AXES];
  logic        [EW-1:0] extent_d   [NUM_AXES];
  logic        [EW-1:0] extent_s1_q[NUM_AXES];

  logic signed [CW-1:0] new_center [NUM_AXES];
  logic        [EW-1:0] new_extent [NUM_AXES];

  // Pipeline control.
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc, load_acc;
  stage_en_t en;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o = rdy1;
  assign in_acc     = in_valid_i && rdy1;
  assign load_acc   = in_acc && (func_i == FUNC_LOAD) && (row_index_i != ROW_INVALID);
  assign v1_d       = in_acc && (func_i == FUNC_XFORM);

  assign en.en2 = rdy2;
  assign en.en3 = rdy3;
  assign en.en4 = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      // Advance each valid bit only when its stage moves.
      if (rdy1) v1_q <= v1_d;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Matrix row write on an accepted load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          coef_q[r][c] <= '0;
        end
        trans_q[r] <= '0;
      end
    end else if (load_acc) begin
      coef_q[row_index_i][0] <= coef_0_i;
      coef_q[row_index_i][1] <= coef_1_i;
      coef_q[row_index_i][2] <= coef_2_i;
      trans_q[row_index_i]   <= translation_i;
    end
  end

  // Magnitudes of the coefficients; the most negative one maps to 2^(CW-1).
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        abs_d[r][c] = coef_q[r][c][CW-1] ? (~coef_q[r][c] + CW'(1)) : coef_q[r][c];
      end
    end
  end

  assign center_d[0] = center_x_i;
  assign center_d[1] = center_y_i;
  assign center_d[2] = center_z_i;
  assign extent_d[0] = extent_x_i;
  assign extent_d[1] = extent_y_i;
  assign extent_d[2] = extent_z_i;

  // Capture the box with the matrix it sees at acceptance.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      coef_s1_q   <= coef_q;
      abs_s1_q    <= abs_d;
      trans_s1_q  <= trans_q;
      center_s1_q <= center_d;
      extent_s1_q <= extent_d;
    end
  end

  for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
    aat_row u_row (
      .clk_i        (clk_i),
      .en_i         (en),
      .coef_i       (coef_s1_q[r]),
      .coef_abs_i   (abs_s1_q[r]),
      .trans_i      (trans_s1_q[r]),
      .center_i     (center_s1_q),
      .extent_i     (extent_s1_q),
      .new_center_o (new_center[r]),
      .new_extent_o (new_extent[r])
    );
  end

  assign out_valid_o    = v4_q;
  assign new_center_x_o = new_center[0];
  assign new_center_y_o = new_center[1];
  assign new_center_z_o = new_center[2];
  assign new_extent_x_o = new_extent[0];
  assign new_extent_y_o = new_extent[1];
  assign new_extent_z_o = new_extent[2];

  // A load never occupies the first stage.
  a_load_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i == FUNC_LOAD) |=> !v1_q)
    else $error("load item entered the pipeline");

  // Input taken under an output stall only if a bubble exists upstream.
  a_stall_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i && in_ready_o) |-> (!v1_q || !v2_q || !v3_q))
    else $error("input accepted with a full stalled pipeline");

  // An item leaving stage 3 reaches the output stage.
  a_stage3_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> v4_q)
    else $error("item lost between stage 3 and output");

  // A stalled result is not dropped.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(new_center_x_o)))
    else $error("stalled result changed");

endmodule

@@ design/aat_row.sv @@
// One output axis of the box transform: products, sums and saturation
// over three register stages. Depends on aat_pkg.
module aat_row import aat_pkg::*; (
  input  logic                  clk_i,
  input  stage_en_t             en_i,
  input  logic signed [CW-1:0]  coef_i     [NUM_AXES],
  input  logic        [CW-1:0]  coef_abs_i [NUM_AXES],
  input  logic signed [CW-1:0]  trans_i,
  input  logic signed [CW-1:0]  center_i   [NUM_AXES],
  input  logic        [EW-1:0]  extent_i   [NUM_AXES],
  output logic signed [CW-1:0]  new_center_o,
  output logic        [EW-1:0]  new_extent_o
);

  logic signed [CPROD_W-1:0] cprod [NUM_AXES];
  logic        [EPROD_W-1:0] eprod [NUM_AXES];

  logic signed [CTERM_W-1:0] cterm_d [NUM_AXES];
  logic signed [CTERM_W-1:0] cterm_q [NUM_AXES];
  logic        [ETERM_W-1:0] eterm_d [NUM_AXES];
  logic        [ETERM_W-1:0] eterm_q [NUM_AXES];
  logic signed [CW-1:0]      trans_q;

  logic signed [CSUM_W-1:0]  csum_d, csum_q;
  logic        [ESUM_W-1:0]  esum_d, esum_q;

  logic signed [CW-1:0]      new_center_d, new_center_q;
  logic        [EW-1:0]      new_extent_d, new_extent_q;

  // Exact products, floored by dropping the fraction bits.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cprod[i]   = CPROD_W'(coef_i[i]) * CPROD_W'(center_i[i]);
      eprod[i]   = EPROD_W'(coef_abs_i[i]) * EPROD_W'(extent_i[i]);
      cterm_d[i] = cprod[i][CPROD_W-1:FB];
      eterm_d[i] = eprod[i][EPROD_W-1:FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      cterm_q <= cterm_d;
      eterm_q <= eterm_d;
      trans_q <= trans_i;
    end
  end

  always_comb begin
    csum_d = {{(CSUM_W-CTERM_W){cterm_q[0][CTERM_W-1]}}, cterm_q[0]}
           + {{(CSUM_W-CTERM_W){cterm_q[1][CTERM_W-1]}}, cterm_q[1]}
           + {{(CSUM_W-CTERM_W){cterm_q[2][CTERM_W-1]}}, cterm_q[2]}
           + {{(CSUM_W-CW){trans_q[CW-1]}}, trans_q};
    esum_d = {{(ESUM_W-ETERM_W){1'b0}}, eterm_q[0]}
           + {{(ESUM_W-ETERM_W){1'b0}}, eterm_q[1]}
           + {{(ESUM_W-ETERM_W){1'b0}}, eterm_q[2]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      csum_q <= csum_d;
      esum_q <= esum_d;
    end
  end

  assign new_center_d = sat_center(csum_q);
  assign new_extent_d = sat_extent(esum_q);

  always_ff @(posedge clk_i) begin
    if (en_i.en4) begin
      new_center_q <= new_center_d;
      new_extent_q <= new_extent_d;
    end
  end

  assign new_center_o = new_center_q;
  assign new_extent_o = new_extent_q;

endmodule
